@@ hdl/particle_fluid_step_assert.svh @@
// ----------------------------------------------------------------------------
// particle_fluid_step_assert.svh
// Assertion macros used by the particle fluid port checker (pfs_checker).
// ----------------------------------------------------------------------------
`ifndef PARTICLE_FLUID_STEP_ASSERT_SVH
`define PARTICLE_FLUID_STEP_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define PFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfs: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define PFS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfs: same-cycle check failed");

`endif

@@ hdl/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg
// Types, constants and helpers of the particle fluid step engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int POS_W      = 20;
    localparam int VEL_W      = 21;
    localparam int WIDE_W     = 22;
    localparam int ARG_W      = 21;
    localparam int PROD_W     = 2 * ARG_W;
    localparam int ROOT_W     = PROD_W / 2;
    localparam int DVD_W      = 32;
    localparam int DVS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GRAV_W     = 12;
    localparam int WALL_W     = 11;
    localparam int FRAC_W     = 16;
    localparam int RND_HALF   = 32768;
    localparam int GRAV_HALF  = 128;

    localparam logic [FRAC_W-1:0] REFLECT_Q16 = 16'd39322;

    localparam logic [GRAV_W-1:0] GRAV_RST   = 12'd900;
    localparam logic [FRAC_W-1:0] RADIUS_RST = 16'd5120;
    localparam logic [FRAC_W-1:0] STIFF_RST  = 16'd29491;
    localparam logic [FRAC_W-1:0] DAMP_RST   = 16'd65208;
    localparam logic [WALL_W-1:0] WALL_L_RST = 11'd100;
    localparam logic [WALL_W-1:0] WALL_R_RST = 11'd800;
    localparam logic [WALL_W-1:0] WALL_T_RST = 11'd100;
    localparam logic [WALL_W-1:0] WALL_B_RST = 11'd650;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide VEL_MAX = 22'sd1048575;
    localparam t_wide VEL_MIN = -22'sd1048576;
    localparam t_wide POS_MAX = 22'sd524287;
    localparam t_wide POS_MIN = -22'sd524288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY = 3'd0,
        CFG_RADIUS  = 3'd1,
        CFG_STIFF   = 3'd2,
        CFG_DAMP    = 3'd3,
        CFG_WALL_L  = 3'd4,
        CFG_WALL_R  = 3'd5,
        CFG_WALL_T  = 3'd6,
        CFG_WALL_B  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [5:0] {
        ST_IDLE, ST_READ, ST_DONE,
        ST_G_MUL, ST_G_SET, ST_G_RD, ST_G_WR,
        ST_P_RDI, ST_P_LDI, ST_P_RDJ, ST_P_DIFF, ST_P_SQX, ST_P_SQY,
        ST_P_SQRT, ST_P_SQW, ST_P_FMUL, ST_P_FSET, ST_P_MX, ST_P_DVX,
        ST_P_DVXW, ST_P_MY, ST_P_DVY, ST_P_DVYW, ST_P_UPD, ST_P_NEXT,
        ST_P_WRI,
        ST_I_RD, ST_I_LD, ST_I_DMX, ST_I_DMY, ST_I_DTX, ST_I_DTY, ST_I_POS,
        ST_W_CHK, ST_W_REF, ST_I_WR
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } t_particle;

    function automatic logic [ARG_W-1:0] f_abs(input t_wide v);
        t_wide m;
        m = (v < 0) ? -v : v;
        return m[ARG_W-1:0];
    endfunction

    // magnitude product / 2^16, rounded half away from zero, sign restored
    function automatic t_wide f_round(input logic neg, input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] r;
        t_wide             m;
        r = (p + PROD_W'(RND_HALF)) >> FRAC_W;
        m = $signed(r[WIDE_W-1:0]);
        return neg ? -m : m;
    endfunction

    function automatic logic signed [VEL_W-1:0] f_sat_vel(input t_wide v);
        t_wide s;
        s = (v > VEL_MAX) ? VEL_MAX : ((v < VEL_MIN) ? VEL_MIN : v);
        return s[VEL_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] f_sat_pos(input t_wide v);
        t_wide s;
        s = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return s[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pfs_mul.sv @@
// ----------------------------------------------------------------------------
// pfs_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_mul (
    input  logic                        i_clk,
    input  logic [pfs_pkg::ARG_W-1:0]   i_a,
    input  logic [pfs_pkg::ARG_W-1:0]   i_b,
    output logic [pfs_pkg::PROD_W-1:0]  o_p
);
    import pfs_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ hdl/pfs_isqrt.sv @@
// ----------------------------------------------------------------------------
// pfs_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfs_pkg::PROD_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [pfs_pkg::ROOT_W-1:0]  o_root
);
    import pfs_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [REM_W-1:0]    n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic [REM_W+1:0]    w_sh;
    logic [REM_W+1:0]    w_trial;

    always_comb begin
        w_sh    = {r_rem, r_rad[PROD_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        if (w_sh >= w_trial) begin
            n_rem  = REM_W'(w_sh - w_trial);
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = REM_W'(w_sh);
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ hdl/pfs_div.sv @@
// ----------------------------------------------------------------------------
// pfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfs_pkg::DVD_W-1:0]   i_dvd,
    input  logic [pfs_pkg::DVS_W-1:0]   i_dvs,
    output logic                        o_done,
    output logic [pfs_pkg::DVS_W-1:0]   o_quo
);
    import pfs_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_q;
    logic [DVS_W-1:0]   r_rem;
    logic [DVS_W-1:0]   r_dvs;
    logic [DVS_W:0]     w_sh;
    logic               w_ge;

    assign w_sh = {r_rem, r_q[DVD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
            r_cnt <= CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_sh - {1'b0, r_dvs}) : DVS_W'(w_sh);
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q[DVS_W-1:0];

endmodule

`default_nettype wire

@@ hdl/particle_fluid_step.sv @@
// ----------------------------------------------------------------------------
// particle_fluid_step
// Particle store with a sequenced fixed-point fluid frame step.
//
//   channel   dir  transfer when          payload
//   request   in   start && !busy         i_req_type .. i_active_count
//   result    out  o_valid (one cycle)    o_out_pos_x .. o_step_done
//   config    in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Write: stored without raising busy; no result. Read: result in the first
// cycle with busy low. Step: busy through a gravity pass over the particles,
// a pair pass (n >= 2) with a root wait per pair and two divide waits per
// touching pair, and an integration pass with wall checks. Result in the
// first cycle with busy low. Synchronous active-low reset restores state and
// config registers; the store persists. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_fluid_step #(
    parameter int MAX_PARTICLES = pfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [5:0]                          i_slot,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_in_pos_x,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_in_pos_y,
    input  logic signed [pfs_pkg::VEL_W-1:0]    i_in_vel_x,
    input  logic signed [pfs_pkg::VEL_W-1:0]    i_in_vel_y,
    input  logic [pfs_pkg::FRAC_W-1:0]          i_time_step,
    input  logic [6:0]                          i_active_count,
    output logic                                o_valid,
    output logic signed [pfs_pkg::POS_W-1:0]    o_out_pos_x,
    output logic signed [pfs_pkg::POS_W-1:0]    o_out_pos_y,
    output logic signed [pfs_pkg::VEL_W-1:0]    o_out_vel_x,
    output logic signed [pfs_pkg::VEL_W-1:0]    o_out_vel_y,
    output logic                                o_step_done,
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pfs_pkg::*;

    localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    t_state r_state, n_state;

    logic [GRAV_W-1:0] r_grav;
    logic [FRAC_W-1:0] r_radius, r_stiff, r_damp;
    logic [WALL_W-1:0] r_wl, r_wr, r_wt, r_wb;

    t_particle r_mem [MAX_PARTICLES];
    t_particle r_rd, r_pi, r_pj;

    logic              r_rdok;
    logic [FRAC_W-1:0] r_dt;
    logic [CW-1:0]     r_n, r_i, r_j;
    t_wide             r_g, r_dx, r_dy, r_ex;
    t_wide             r_px, r_py, r_vx, r_vy;
    logic [PROD_W-1:0] r_acc;
    logic [ROOT_W-1:0] r_dist;
    logic [FRAC_W-1:0] r_force;
    logic [1:0]        r_w;

    logic                    r_valid, r_odone;
    logic signed [POS_W-1:0] r_opx, r_opy;
    logic signed [VEL_W-1:0] r_ovx, r_ovy;

    logic [IW-1:0]     w_raddr, w_waddr;
    logic              w_we;
    t_particle         w_wdata;
    logic [ARG_W-1:0]  w_ma, w_mb;
    logic [PROD_W-1:0] w_prod;
    logic              w_sq_start, w_sq_done;
    logic [PROD_W-1:0] w_sq_rad;
    logic [ROOT_W-1:0] w_sq_root;
    logic              w_dv_start, w_dv_done;
    logic [DVS_W-1:0]  w_dv_quo;
    t_wide             w_q, w_ey, w_bound;
    logic              w_hit, w_slot_ok, w_touch;

    pfs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    pfs_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_sq_rad),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    pfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_dvd   (w_prod[DVD_W-1:0]),
        .i_dvs   (r_dist[DVS_W-1:0]),
        .o_done  (w_dv_done),
        .o_quo   (w_dv_quo)
    );

    assign w_slot_ok = (7'(i_slot) < 7'(MAX_PARTICLES));
    assign w_touch   = (w_sq_root != '0) && (w_sq_root < ROOT_W'(r_radius));
    assign w_q       = t_wide'($signed({1'b0, w_dv_quo}));
    assign w_ey      = (r_dy < 0) ? -w_q : w_q;

    always_comb begin
        case (r_w)
            2'd0:    w_bound = $signed({3'b000, r_wl, 8'h00});
            2'd1:    w_bound = $signed({3'b000, r_wr, 8'h00});
            2'd2:    w_bound = $signed({3'b000, r_wt, 8'h00});
            default: w_bound = $signed({3'b000, r_wb, 8'h00});
        endcase
        case (r_w)
            2'd0:    w_hit = (r_px < w_bound);
            2'd1:    w_hit = (r_px > w_bound);
            2'd2:    w_hit = (r_py < w_bound);
            default: w_hit = (r_py > w_bound);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_req'(i_req_type))
                        REQ_STEP: n_state = ST_G_MUL;
                        REQ_READ: n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   n_state = ST_IDLE;
            ST_DONE:   n_state = ST_IDLE;
            ST_G_MUL:  n_state = ST_G_SET;
            ST_G_SET:  n_state = (r_n == '0) ? ST_DONE : ST_G_RD;
            ST_G_RD:   n_state = ST_G_WR;
            ST_G_WR: begin
                if (CW'(r_i + 1'b1) != r_n) begin
                    n_state = ST_G_RD;
                end else if (r_n < CW'(2)) begin
                    n_state = ST_I_RD;
                end else begin
                    n_state = ST_P_RDI;
                end
            end
            ST_P_RDI:  n_state = ST_P_LDI;
            ST_P_LDI:  n_state = ST_P_RDJ;
            ST_P_RDJ:  n_state = ST_P_DIFF;
            ST_P_DIFF: n_state = ST_P_SQX;
            ST_P_SQX:  n_state = ST_P_SQY;
            ST_P_SQY:  n_state = ST_P_SQRT;
            ST_P_SQRT: n_state = ST_P_SQW;
            ST_P_SQW: begin
                if (w_sq_done) begin
                    n_state = w_touch ? ST_P_FMUL : ST_P_NEXT;
                end
            end
            ST_P_FMUL: n_state = ST_P_FSET;
            ST_P_FSET: n_state = ST_P_MX;
            ST_P_MX:   n_state = ST_P_DVX;
            ST_P_DVX:  n_state = ST_P_DVXW;
            ST_P_DVXW: n_state = w_dv_done ? ST_P_MY : ST_P_DVXW;
            ST_P_MY:   n_state = ST_P_DVY;
            ST_P_DVY:  n_state = ST_P_DVYW;
            ST_P_DVYW: n_state = w_dv_done ? ST_P_UPD : ST_P_DVYW;
            ST_P_UPD:  n_state = ST_P_NEXT;
            ST_P_NEXT: n_state = (CW'(r_j + 1'b1) == r_n) ? ST_P_WRI : ST_P_RDJ;
            ST_P_WRI: begin
                n_state = (({1'b0, r_i} + (CW+1)'(2)) >= {1'b0, r_n}) ? ST_I_RD : ST_P_RDI;
            end
            ST_I_RD:   n_state = ST_I_LD;
            ST_I_LD:   n_state = ST_I_DMX;
            ST_I_DMX:  n_state = ST_I_DMY;
            ST_I_DMY:  n_state = ST_I_DTX;
            ST_I_DTX:  n_state = ST_I_DTY;
            ST_I_DTY:  n_state = ST_I_POS;
            ST_I_POS:  n_state = ST_W_CHK;
            ST_W_CHK: begin
                if (w_hit) begin
                    n_state = ST_W_REF;
                end else if (r_w == 2'd3) begin
                    n_state = ST_I_WR;
                end
            end
            ST_W_REF:  n_state = (r_w == 2'd3) ? ST_I_WR : ST_W_CHK;
            ST_I_WR:   n_state = (CW'(r_i + 1'b1) == r_n) ? ST_DONE : ST_I_RD;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: store port, shared unit operands, unit starts
    always_comb begin
        w_raddr    = r_i[IW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_i[IW-1:0];
        w_wdata    = r_pi;
        w_ma       = '0;
        w_mb       = '0;
        w_sq_start = 1'b0;
        w_sq_rad   = r_acc + w_prod;
        w_dv_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_raddr    = i_slot[IW-1:0];
                w_waddr    = i_slot[IW-1:0];
                w_we       = start && (i_req_type == REQ_WRITE) && w_slot_ok;
                w_wdata.px = i_in_pos_x;
                w_wdata.py = i_in_pos_y;
                w_wdata.vx = i_in_vel_x;
                w_wdata.vy = i_in_vel_y;
            end
            ST_G_MUL: begin
                w_ma = ARG_W'(r_grav);
                w_mb = ARG_W'(r_dt);
            end
            ST_G_WR: begin
                w_we       = 1'b1;
                w_wdata    = r_rd;
                w_wdata.vy = f_sat_vel(t_wide'(r_rd.vy) + r_g);
            end
            ST_P_RDJ:  w_raddr = r_j[IW-1:0];
            ST_P_SQX: begin
                w_ma = f_abs(r_dx);
                w_mb = f_abs(r_dx);
            end
            ST_P_SQY: begin
                w_ma = f_abs(r_dy);
                w_mb = f_abs(r_dy);
            end
            ST_P_SQRT: w_sq_start = 1'b1;
            ST_P_FMUL: begin
                w_ma = ARG_W'(r_radius - r_dist[FRAC_W-1:0]);
                w_mb = ARG_W'(r_stiff);
            end
            ST_P_MX: begin
                w_ma = f_abs(r_dx);
                w_mb = ARG_W'(r_force);
            end
            ST_P_DVX:  w_dv_start = 1'b1;
            ST_P_MY: begin
                w_ma = f_abs(r_dy);
                w_mb = ARG_W'(r_force);
            end
            ST_P_DVY:  w_dv_start = 1'b1;
            ST_P_UPD: begin
                w_we       = 1'b1;
                w_waddr    = r_j[IW-1:0];
                w_wdata    = r_pj;
                w_wdata.vx = f_sat_vel(t_wide'(r_pj.vx) + r_ex);
                w_wdata.vy = f_sat_vel(t_wide'(r_pj.vy) + w_ey);
            end
            ST_P_WRI:  w_we = 1'b1;
            ST_I_DMX: begin
                w_ma = f_abs(t_wide'(r_pi.vx));
                w_mb = ARG_W'(r_damp);
            end
            ST_I_DMY: begin
                w_ma = f_abs(t_wide'(r_pi.vy));
                w_mb = ARG_W'(r_damp);
            end
            ST_I_DTX: begin
                w_ma = f_abs(r_vx);
                w_mb = ARG_W'(r_dt);
            end
            ST_I_DTY: begin
                w_ma = f_abs(r_vy);
                w_mb = ARG_W'(r_dt);
            end
            ST_W_CHK: begin
                w_ma = r_w[1] ? f_abs(r_vy) : f_abs(r_vx);
                w_mb = ARG_W'(REFLECT_Q16);
            end
            ST_I_WR: begin
                w_we       = 1'b1;
                w_wdata.px = r_px[POS_W-1:0];
                w_wdata.py = r_py[POS_W-1:0];
                w_wdata.vx = f_sat_vel(r_vx);
                w_wdata.vy = f_sat_vel(r_vy);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_grav   <= GRAV_RST;
            r_radius <= RADIUS_RST;
            r_stiff  <= STIFF_RST;
            r_damp   <= DAMP_RST;
            r_wl     <= WALL_L_RST;
            r_wr     <= WALL_R_RST;
            r_wt     <= WALL_T_RST;
            r_wb     <= WALL_B_RST;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_READ) || (r_state == ST_DONE);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GRAVITY: r_grav   <= i_cfg_data[GRAV_W-1:0];
                    CFG_RADIUS:  r_radius <= i_cfg_data;
                    CFG_STIFF:   r_stiff  <= i_cfg_data;
                    CFG_DAMP:    r_damp   <= i_cfg_data;
                    CFG_WALL_L:  r_wl     <= i_cfg_data[WALL_W-1:0];
                    CFG_WALL_R:  r_wr     <= i_cfg_data[WALL_W-1:0];
                    CFG_WALL_T:  r_wt     <= i_cfg_data[WALL_W-1:0];
                    CFG_WALL_B:  r_wb     <= i_cfg_data[WALL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_rdok <= w_slot_ok;
                    r_dt   <= i_time_step;
                    r_n    <= (i_active_count > 7'(MAX_PARTICLES)) ?
                              CW'(MAX_PARTICLES) : i_active_count[CW-1:0];
                    r_i    <= '0;
                end
            end
            ST_READ: begin
                r_opx   <= r_rdok ? r_rd.px : '0;
                r_opy   <= r_rdok ? r_rd.py : '0;
                r_ovx   <= r_rdok ? r_rd.vx : '0;
                r_ovy   <= r_rdok ? r_rd.vy : '0;
                r_odone <= 1'b0;
            end
            ST_DONE: begin
                r_opx   <= '0;
                r_opy   <= '0;
                r_ovx   <= '0;
                r_ovy   <= '0;
                r_odone <= 1'b1;
            end
            ST_G_SET: begin
                r_g <= $signed(WIDE_W'((w_prod + PROD_W'(GRAV_HALF)) >> 8));
            end
            ST_G_WR: begin
                r_i <= (CW'(r_i + 1'b1) == r_n) ? '0 : CW'(r_i + 1'b1);
            end
            ST_P_RDI:  r_j  <= CW'(r_i + 1'b1);
            ST_P_LDI:  r_pi <= r_rd;
            ST_P_DIFF: begin
                r_pj <= r_rd;
                r_dx <= t_wide'(r_rd.px) - t_wide'(r_pi.px);
                r_dy <= t_wide'(r_rd.py) - t_wide'(r_pi.py);
            end
            ST_P_SQY:  r_acc <= w_prod;
            ST_P_SQW: begin
                if (w_sq_done) begin
                    r_dist <= w_sq_root;
                end
            end
            ST_P_FSET: r_force <= w_prod[2*FRAC_W-1:FRAC_W];
            ST_P_DVXW: begin
                if (w_dv_done) begin
                    r_ex <= (r_dx < 0) ? -w_q : w_q;
                end
            end
            ST_P_UPD: begin
                r_pi.vx <= f_sat_vel(t_wide'(r_pi.vx) - r_ex);
                r_pi.vy <= f_sat_vel(t_wide'(r_pi.vy) - w_ey);
            end
            ST_P_NEXT: r_j <= CW'(r_j + 1'b1);
            ST_P_WRI: begin
                r_i <= (({1'b0, r_i} + (CW+1)'(2)) >= {1'b0, r_n}) ? '0 : CW'(r_i + 1'b1);
            end
            ST_I_LD:   r_pi <= r_rd;
            ST_I_DMY:  r_vx <= f_round(r_pi.vx < 0, w_prod);
            ST_I_DTX:  r_vy <= f_round(r_pi.vy < 0, w_prod);
            ST_I_DTY: begin
                r_px <= t_wide'(f_sat_pos(t_wide'(r_pi.px) + f_round(r_vx < 0, w_prod)));
            end
            ST_I_POS: begin
                r_py <= t_wide'(f_sat_pos(t_wide'(r_pi.py) + f_round(r_vy < 0, w_prod)));
                r_w  <= 2'd0;
            end
            ST_W_CHK: begin
                if (w_hit) begin
                    if (r_w[1]) begin
                        r_py <= w_bound;
                    end else begin
                        r_px <= w_bound;
                    end
                end else begin
                    r_w <= r_w + 2'd1;
                end
            end
            ST_W_REF: begin
                if (r_w[1]) begin
                    r_vy <= f_round(!(r_vy < 0), w_prod);
                end else begin
                    r_vx <= f_round(!(r_vx < 0), w_prod);
                end
                r_w <= r_w + 2'd1;
            end
            ST_I_WR:   r_i <= CW'(r_i + 1'b1);
            default: ;
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_out_pos_x = r_opx;
    assign o_out_pos_y = r_opy;
    assign o_out_vel_x = r_ovx;
    assign o_out_vel_y = r_ovy;
    assign o_step_done = r_odone;

endmodule

`default_nettype wire

@@ hdl/pfs_checker.sv @@
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the particle fluid step engine, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "particle_fluid_step_assert.svh"

module pfs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic                                o_valid,
    input  logic                                o_step_done,
    input  logic signed [pfs_pkg::POS_W-1:0]    o_out_pos_x,
    input  logic signed [pfs_pkg::VEL_W-1:0]    o_out_vel_y
);
    import pfs_pkg::*;

    logic w_take;

    assign w_take = start && !busy;

    `PFS_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, w_take && (i_req_type == REQ_READ), busy)
    `PFS_ASSERT_NEXT(a_write_quiet, i_clk, i_rst_n, w_take && (i_req_type == REQ_WRITE), !busy && !o_valid)
    `PFS_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `PFS_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `PFS_ASSERT_NOW(a_step_zero, i_clk, i_rst_n, o_valid && o_step_done, (o_out_pos_x == 0) && (o_out_vel_y == 0))

endmodule

bind particle_fluid_step pfs_checker u_pfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .o_valid     (o_valid),
    .o_step_done (o_step_done),
    .o_out_pos_x (o_out_pos_x),
    .o_out_vel_y (o_out_vel_y)
);

`default_nettype wire

@@ verif/particle_fluid_step_checker.sv @@
// ----------------------------------------------------------------------------
// particle_fluid_step_checker
// Watches the request, config and result channels of particle_fluid_step,
// keeps its own copy of the particle store and registers, predicts every
// read and step result and compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_fluid_step_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [5:0]                          i_slot,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_in_pos_x,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_in_pos_y,
    input  logic signed [pfs_pkg::VEL_W-1:0]    i_in_vel_x,
    input  logic signed [pfs_pkg::VEL_W-1:0]    i_in_vel_y,
    input  logic [pfs_pkg::FRAC_W-1:0]          i_time_step,
    input  logic [6:0]                          i_active_count,
    input  logic                                o_valid,
    input  logic signed [pfs_pkg::POS_W-1:0]    o_out_pos_x,
    input  logic signed [pfs_pkg::POS_W-1:0]    o_out_pos_y,
    input  logic signed [pfs_pkg::VEL_W-1:0]    o_out_vel_x,
    input  logic signed [pfs_pkg::VEL_W-1:0]    o_out_vel_y,
    input  logic                                o_step_done,
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import pfs_pkg::*;

    localparam int NP = MAX_PARTICLES_DEF;

    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic                    done;
    } t_particle_reply;

    t_particle_reply reply_q[$];

    longint p_x[NP], p_y[NP], v_x[NP], v_y[NP];
    longint unsigned grav, radius, stiff, damp, w_l, w_r, w_t, w_b;

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        for (int k = 0; k < NP; k++) begin
            p_x[k] = 0; p_y[k] = 0; v_x[k] = 0; v_y[k] = 0;
        end
    end

    assign o_pending = reply_q.size();

    function automatic longint clip(input longint v, input int w);
        longint lim;
        lim = longint'(1) << (w - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // a * b / 2^16, rounded half away from zero
    function automatic longint scale_q16(input longint a, input longint unsigned b);
        longint unsigned mag, r;
        mag = (a < 0) ? longint'(-a) : a;
        r = (mag * b + 64'd32768) >> 16;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint push_part(input longint d, input longint unsigned f,
                                         input longint unsigned span);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? longint'(-d) : d;
        q = longint'((mag * f) / span);
        return (d < 0) ? -q : q;
    endfunction

    task automatic bounce(inout longint p, inout longint v,
                          input longint unsigned lo, input longint unsigned hi);
        longint l, h;
        l = longint'(lo << 8);
        h = longint'(hi << 8);
        if (p < l) begin
            p = l;
            v = -scale_q16(v, REFLECT_Q16);
        end
        if (p > h) begin
            p = h;
            v = -scale_q16(v, REFLECT_Q16);
        end
    endtask

    task automatic advance_frame(input int n, input longint unsigned dt);
        longint g, dx, dy, ex, ey, vx, vy, px, py;
        longint unsigned d2, sep, f;
        g = longint'((grav * dt + 128) >> 8);
        for (int i = 0; i < n; i++) v_y[i] = clip(v_y[i] + g, VEL_W);
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                dx = p_x[j] - p_x[i];
                dy = p_y[j] - p_y[i];
                d2 = longint'(dx * dx) + longint'(dy * dy);
                sep = root_floor(d2);
                if (sep > 0 && sep < radius) begin
                    f = ((radius - sep) * stiff) >> 16;
                    ex = push_part(dx, f, sep);
                    ey = push_part(dy, f, sep);
                    v_x[i] = clip(v_x[i] - ex, VEL_W);
                    v_y[i] = clip(v_y[i] - ey, VEL_W);
                    v_x[j] = clip(v_x[j] + ex, VEL_W);
                    v_y[j] = clip(v_y[j] + ey, VEL_W);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            vx = scale_q16(v_x[i], damp);
            vy = scale_q16(v_y[i], damp);
            px = clip(p_x[i] + scale_q16(vx, dt), POS_W);
            py = clip(p_y[i] + scale_q16(vy, dt), POS_W);
            bounce(px, vx, w_l, w_r);
            bounce(py, vy, w_t, w_b);
            p_x[i] = px;
            p_y[i] = py;
            v_x[i] = clip(vx, VEL_W);
            v_y[i] = clip(vy, VEL_W);
        end
    endtask

    task automatic check_reply();
        t_particle_reply e;
        if (reply_q.size() == 0) begin
            $error("unexpected result: step_done %0d pos_x %0d", o_step_done, o_out_pos_x);
            o_fail_count++;
            return;
        end
        e = reply_q.pop_front();
        o_checked++;
        if (o_out_pos_x !== e.px) begin
            $error("out_pos_x expected %0d actual %0d", e.px, o_out_pos_x);
            o_fail_count++;
        end
        if (o_out_pos_y !== e.py) begin
            $error("out_pos_y expected %0d actual %0d", e.py, o_out_pos_y);
            o_fail_count++;
        end
        if (o_out_vel_x !== e.vx) begin
            $error("out_vel_x expected %0d actual %0d", e.vx, o_out_vel_x);
            o_fail_count++;
        end
        if (o_out_vel_y !== e.vy) begin
            $error("out_vel_y expected %0d actual %0d", e.vy, o_out_vel_y);
            o_fail_count++;
        end
        if (o_step_done !== e.done) begin
            $error("step_done expected %0d actual %0d", e.done, o_step_done);
            o_fail_count++;
        end
    endtask

    task automatic take_request();
        t_particle_reply r;
        int n;
        r = '{px: '0, py: '0, vx: '0, vy: '0, done: 1'b0};
        case (t_req'(i_req_type))
            REQ_WRITE: begin
                p_x[i_slot] = i_in_pos_x;
                p_y[i_slot] = i_in_pos_y;
                v_x[i_slot] = i_in_vel_x;
                v_y[i_slot] = i_in_vel_y;
            end
            REQ_STEP: begin
                n = (i_active_count > NP) ? NP : int'(i_active_count);
                advance_frame(n, i_time_step);
                r.done = 1'b1;
                reply_q = {reply_q, r};
            end
            REQ_READ: begin
                r.px = p_x[i_slot][POS_W-1:0];
                r.py = p_y[i_slot][POS_W-1:0];
                r.vx = v_x[i_slot][VEL_W-1:0];
                r.vy = v_y[i_slot][VEL_W-1:0];
                reply_q = {reply_q, r};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grav   = GRAV_RST;
            radius = RADIUS_RST;
            stiff  = STIFF_RST;
            damp   = DAMP_RST;
            w_l = WALL_L_RST; w_r = WALL_R_RST; w_t = WALL_T_RST; w_b = WALL_B_RST;
        end else begin
            if (o_valid) check_reply();
            if (start && !busy) take_request();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GRAVITY: grav   = i_cfg_data[GRAV_W-1:0];
                    CFG_RADIUS:  radius = i_cfg_data;
                    CFG_STIFF:   stiff  = i_cfg_data;
                    CFG_DAMP:    damp   = i_cfg_data;
                    CFG_WALL_L:  w_l    = i_cfg_data[WALL_W-1:0];
                    CFG_WALL_R:  w_r    = i_cfg_data[WALL_W-1:0];
                    CFG_WALL_T:  w_t    = i_cfg_data[WALL_W-1:0];
                    CFG_WALL_B:  w_b    = i_cfg_data[WALL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ verif/particle_fluid_step_test.sv @@
// ----------------------------------------------------------------------------
// particle_fluid_step_test
// Drives particle_fluid_step through four register settings (defaults,
// extremes, crossed walls, no interaction) with directed and random
// write, read and step requests, with and without sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_fluid_step_test;
    import pfs_pkg::*;

    localparam int QUIET_LIMIT = 1000000;
    localparam int RAND_PER_PHASE = 8;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 i_req_type = '0;
    logic [5:0]                 i_slot = '0;
    logic signed [POS_W-1:0]    i_in_pos_x = '0;
    logic signed [POS_W-1:0]    i_in_pos_y = '0;
    logic signed [VEL_W-1:0]    i_in_vel_x = '0;
    logic signed [VEL_W-1:0]    i_in_vel_y = '0;
    logic [FRAC_W-1:0]          i_time_step = '0;
    logic [6:0]                 i_active_count = '0;
    logic                       o_valid;
    logic signed [POS_W-1:0]    o_out_pos_x, o_out_pos_y;
    logic signed [VEL_W-1:0]    o_out_vel_x, o_out_vel_y;
    logic                       o_step_done;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    int fail_count, pending, checked;
    int sent = 0;
    int quiet = 0;
    int gap_pct = 0;
    bit written[64];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    particle_fluid_step DUT (.*);

    particle_fluid_step_checker u_checker (
        .*, .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input t_req req, input int slot, input int px, input int py,
                        input int vx, input int vy, input int dt, input int cnt);
        int g;
        if ($urandom_range(99) < gap_pct) begin
            g = $urandom_range(1, 12);
            @(negedge i_clk);
            start = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = req;
        i_slot = 6'(slot);
        i_in_pos_x = POS_W'(px);
        i_in_pos_y = POS_W'(py);
        i_in_vel_x = VEL_W'(vx);
        i_in_vel_y = VEL_W'(vy);
        i_time_step = FRAC_W'(dt);
        i_active_count = 7'(cnt);
        do @(posedge i_clk); while (busy);
        if (req == REQ_WRITE) written[slot] = 1'b1;
        if (req != REQ_NONE) sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input int data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = CFG_DATA_W'(data);
    endtask

    task automatic set_all(input int g, input int r, input int s, input int d,
                           input int l, input int rt, input int t, input int b);
        set_reg(CFG_GRAVITY, g);
        set_reg(CFG_RADIUS, r);
        set_reg(CFG_STIFF, s);
        set_reg(CFG_DAMP, d);
        set_reg(CFG_WALL_L, l);
        set_reg(CFG_WALL_R, rt);
        set_reg(CFG_WALL_T, t);
        set_reg(CFG_WALL_B, b);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic int prefix();
        int n;
        n = 0;
        while (n < 64 && written[n]) n++;
        return n;
    endfunction

    // mostly clustered particles inside the box, sometimes any value
    function automatic int pick_pos();
        if ($urandom_range(9) < 2) return $signed(20'($urandom));
        return (300 << 8) + $urandom_range(0, 30 << 8);
    endfunction

    function automatic int pick_vel();
        if ($urandom_range(9) < 2) return $signed(21'($urandom));
        return $urandom_range(0, 400 << 8) - (200 << 8);
    endfunction

    task automatic random_items(input int max_n);
        int k, sel, p, s, dt, n;
        k = 0;
        while (k < RAND_PER_PHASE) begin
            sel = $urandom_range(99);
            p = prefix();
            dt = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : 1092;
            if (sel < 8) begin
                send(REQ_NONE, $urandom_range(63), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(127));
            end else begin
                if (sel < 45 || p == 0) begin
                    s = ($urandom_range(3) == 0) ? $urandom_range(63)
                                                 : $urandom_range(0, (p < 63) ? p : 63);
                    send(REQ_WRITE, s, pick_pos(), pick_pos(), pick_vel(), pick_vel(),
                         $urandom, $urandom_range(127));
                end else if (sel < 72) begin
                    send(REQ_READ, $urandom_range(0, p - 1), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom_range(127));
                end else begin
                    n = $urandom_range(0, (p < max_n) ? p : max_n);
                    send(REQ_STEP, $urandom_range(63), $urandom, $urandom, $urandom,
                         $urandom, dt, n);
                end
                k++;
            end
        end
    endtask

    initial begin
        int n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // phase 1: reset values, back-to-back requests, directed cases
        gap_pct = 0;
        set_all(900, 5120, 29491, 65208, 100, 800, 100, 650);
        send(REQ_WRITE, 0, 524287, -524288, -1048576, 1048575, 0, 0);
        send(REQ_WRITE, 1, -524288, 524287, 1048575, -1048576, 65535, 127);
        send(REQ_WRITE, 2, 400 << 8, 400 << 8, 0, 0, 0, 0);
        send(REQ_WRITE, 3, 410 << 8, 405 << 8, 100 << 8, -(50 << 8), 0, 0);
        send(REQ_WRITE, 4, 410 << 8, 405 << 8, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
        send(REQ_NONE, 5, 0, 0, 0, 0, 0, 0);
        send(REQ_STEP, 0, 0, 0, 0, 0, 1092, 0);
        send(REQ_STEP, 0, 0, 0, 0, 0, 65535, 5);
        for (int s = 0; s < 5; s++) send(REQ_READ, s, 0, 0, 0, 0, 0, 0);
        send(REQ_STEP, 0, 0, 0, 0, 0, 0, 5);
        send(REQ_READ, 3, 0, 0, 0, 0, 0, 0);
        send(REQ_WRITE, 63, 123456, -654321 >>> 2, 777, -999, 0, 0);
        send(REQ_READ, 63, 0, 0, 0, 0, 0, 0);
        random_items(8);
        drain();

        // phase 2: register extremes, frequent sender gaps
        gap_pct = 58;
        set_all(16'hFFFF, 65535, 65535, 65535, 16'hF800, 2047, 0, 2047);
        random_items(8);
        drain();

        // phase 3: crossed walls; pause for all results mid-phase
        gap_pct = 0;
        set_all(0, 3000, 40000, 60000, 700, 200, 600, 150);
        random_items(8);
        drain();
        random_items(8);
        drain();

        // phase 4: no interaction, fill the store and step it whole
        gap_pct = 29;
        set_all(4095, 0, 0, 0, 0, 2047, 0, 2047);
        for (int s = 0; s < 64; s++)
            if (!written[s])
                send(REQ_WRITE, s, pick_pos(), pick_pos(), pick_vel(), pick_vel(), 0, 0);
        n = 64;
        send(REQ_STEP, 0, 0, 0, 0, 0, 1092, n);
        send(REQ_STEP, 0, 0, 0, 0, 0, 65535, 127);
        send(REQ_STEP, 0, 0, 0, 0, 0, 2000, 100);
        send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 63, 0, 0, 0, 0, 0, 0);
        random_items(8);
        drain();

        $display("ran %0d requests over four register settings, %0d results checked",
                 sent, checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ particle_fluid_step.f @@
+incdir+hdl
hdl/pfs_pkg.sv
hdl/pfs_mul.sv
hdl/pfs_isqrt.sv
hdl/pfs_div.sv
hdl/particle_fluid_step.sv
hdl/pfs_checker.sv
verif/particle_fluid_step_checker.sv
verif/particle_fluid_step_test.sv
